// ===== design/axis_angle_vertex_transform_macros.svh =====
// Assertion macros for the axis-angle vertex transform modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef AXIS_ANGLE_VERTEX_TRANSFORM_MACROS_SVH
`define AXIS_ANGLE_VERTEX_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define AAVT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define AAVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AAVT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define AAVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/aavt_pkg.sv =====
// Types, constants and the arctangent table of the axis-angle vertex transform.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package aavt_pkg;

	// Angle constants in Q4.28 radians.
	localparam logic signed [32:0] ANG_PI      = 33'sd843314857;
	localparam logic signed [32:0] ANG_HALF_PI = 33'sd421657428;
	localparam logic signed [32:0] ANG_TWO_PI  = 33'sd1686629713;

	// CORDIC start value: converged gain in Q30.
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// Number of arctangent table entries.
	localparam int ATAN_ENTRIES = 24;

	// Depth of the queue between front and back.
	localparam int QDEPTH = 4;

	// Stream widths.
	localparam int IN_W  = 304;
	localparam int OUT_W = 128;

	// Vertex payload carried through the block.
	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][31:0] pos;
		logic [2:0][15:0] a;
		logic [31:0]      color;
	} vtx_t;

	// Queue entry: vertex plus reduced angle and quadrant flip.
	typedef struct packed {
		vtx_t               vtx;
		logic signed [31:0] ang;
		logic               flip;
	} item_t;

	// Arctangent of 2^-i in Q28.
	function automatic logic [31:0] atan_q28(input logic [4:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:  r = 32'd210828714;
			5'd1:  r = 32'd124459457;
			5'd2:  r = 32'd65760959;
			5'd3:  r = 32'd33381290;
			5'd4:  r = 32'd16755422;
			5'd5:  r = 32'd8385879;
			5'd6:  r = 32'd4193963;
			5'd7:  r = 32'd2097109;
			5'd8:  r = 32'd1048571;
			5'd9:  r = 32'd524287;
			5'd10: r = 32'd262144;
			5'd11: r = 32'd131072;
			5'd12: r = 32'd65536;
			5'd13: r = 32'd32768;
			5'd14: r = 32'd16384;
			5'd15: r = 32'd8192;
			5'd16: r = 32'd4096;
			5'd17: r = 32'd2048;
			5'd18: r = 32'd1024;
			5'd19: r = 32'd512;
			5'd20: r = 32'd256;
			5'd21: r = 32'd128;
			5'd22: r = 32'd64;
			5'd23: r = 32'd32;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/aavt_front.sv =====
// Front part: accepts vertex transfers, reduces the angle to a quadrant and
// scales the alpha byte. Depends on aavt_pkg.
`default_nettype none
module aavt_front
	import aavt_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [IN_W-1:0] s_axis_tdata,
	output logic                 item_valid,
	input  wire logic            item_ready,
	output item_t                item
);

	logic               front_v_q;
	item_t              item_q;
	item_t              item_d;
	logic signed [32:0] z0;
	logic signed [32:0] z1;
	logic signed [32:0] z2;
	logic               flip;
	logic [16:0]        alpha_prod;
	logic [8:0]         alpha_raw;
	logic [7:0]         alpha;
	logic               take;

	// Angle reduction into [-pi/2, pi/2] with a flip of both outputs.
	always_comb begin
		z0 = 33'($signed({s_axis_tdata[287:272], 16'h0000}));
		if (z0 > ANG_PI) begin
			z1 = z0 - ANG_TWO_PI;
		end else if (z0 < -ANG_PI) begin
			z1 = z0 + ANG_TWO_PI;
		end else begin
			z1 = z0;
		end
		flip = 1'b0;
		if (z1 > ANG_HALF_PI) begin
			z2 = z1 - ANG_PI;
			flip = 1'b1;
		end else if (z1 < -ANG_HALF_PI) begin
			z2 = z1 + ANG_PI;
			flip = 1'b1;
		end else begin
			z2 = z1;
		end
	end

	// Alpha scaling, truncating, saturated at full byte.
	always_comb begin
		alpha_prod = 17'(s_axis_tdata[127:120]) * 17'(s_axis_tdata[296:288]);
		alpha_raw  = alpha_prod[16:8];
		alpha      = (alpha_raw > 9'd255) ? 8'hFF : alpha_raw[7:0];
	end

	// Unpack the transfer into a queue entry.
	always_comb begin
		item_d.vtx.p[0]   = s_axis_tdata[31:0];
		item_d.vtx.p[1]   = s_axis_tdata[63:32];
		item_d.vtx.p[2]   = s_axis_tdata[95:64];
		item_d.vtx.color  = {alpha, s_axis_tdata[119:96]};
		item_d.vtx.pos[0] = s_axis_tdata[159:128];
		item_d.vtx.pos[1] = s_axis_tdata[191:160];
		item_d.vtx.pos[2] = s_axis_tdata[223:192];
		item_d.vtx.a[0]   = s_axis_tdata[239:224];
		item_d.vtx.a[1]   = s_axis_tdata[255:240];
		item_d.vtx.a[2]   = s_axis_tdata[271:256];
		item_d.ang        = z2[31:0];
		item_d.flip       = flip;
	end

	assign s_axis_tready = !front_v_q || item_ready;
	assign take          = s_axis_tvalid && s_axis_tready;

	// Front register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_q <= 1'b0;
		end else if (s_axis_tready) begin
			front_v_q <= s_axis_tvalid;
		end
	end

	// Front register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item_d;
		end
	end

	assign item_valid = front_v_q;
	assign item       = item_q;

endmodule
`default_nettype wire

// ===== design/aavt_queue.sv =====
// Short queue between front and back so that each side stalls on its own.
// Depends on aavt_pkg and the assertion macro header.
`default_nettype none
`include "axis_angle_vertex_transform_macros.svh"
module aavt_queue
	import aavt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  item_t      wr_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      rd_item,
	output logic       nempty
);

	localparam int PW = $clog2(QDEPTH);

	item_t         mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = (count_q == (PW+1)'(QDEPTH));
	assign nempty  = (count_q != '0);
	assign rd_item = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	`AAVT_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= (PW+1)'(QDEPTH))
	`AAVT_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)
	`AAVT_ASSERT_NEXT(a_count_dn, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule
`default_nettype wire

// ===== design/aavt_back.sv =====
// Back part: pipelined CORDIC for sine and cosine, then the Rodrigues rotation,
// chunk offset and saturation, ending in the output register. Depends on aavt_pkg.
`default_nettype none
module aavt_back
	import aavt_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_pop,
	input  item_t                 item,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata
);

	localparam int N   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
	localparam int TOP = N + 6;

	logic [TOP:0] vld_q;
	logic         adv;

	// CORDIC stage registers.
	logic signed [33:0] cx_s [N+1];
	logic signed [33:0] cy_s [N+1];
	logic signed [31:0] cz_s [N+1];
	vtx_t               cv_s [N+1];
	logic               cf_s [N+1];

	// Math stage registers.
	logic signed [17:0] sin_s1, cos_s1, sin_s2, cos_s2;
	logic signed [47:0] prod_s1 [3][3];
	vtx_t               vtx_s1, vtx_s2, vtx_s3, vtx_s4, vtx_s5;
	logic signed [35:0] dot_s2;
	logic signed [35:0] cr_s2 [3];
	logic signed [17:0] omc_s2, omc_s3, omc_s4;
	logic signed [51:0] adr_s3 [3];
	logic signed [49:0] pc_s3 [3], pc_s4 [3], pc_s5 [3];
	logic signed [53:0] crs_s3 [3], crs_s4 [3], crs_s5 [3];
	logic signed [37:0] ad_s4 [3];
	logic signed [55:0] adt_s5 [3];
	logic [2:0][31:0]   world_s6;
	logic [31:0]        color_s6;

	// Combinational intermediates.
	logic signed [17:0] cos_r, sin_r;
	logic signed [49:0] dsum;
	logic signed [48:0] cdiff [3];
	logic signed [57:0] tsum [3];
	logic signed [43:0] trnd [3];
	logic signed [44:0] wsum [3];
	logic [2:0][31:0]   world_d;

	// Whole pipeline advances when the output register is free or drains.
	assign adv      = !vld_q[TOP] || m_axis_tready;
	assign item_pop = adv && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOP-1:0], item_valid};
		end
	end

	// CORDIC load.
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0] <= CORDIC_GAIN;
			cy_s[0] <= '0;
			cz_s[0] <= item.ang;
			cv_s[0] <= item.vtx;
			cf_s[0] <= item.flip;
		end
	end

	// One CORDIC micro-rotation per stage.
	for (genvar i = 0; i < N; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cz_s[i][31]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - $signed(atan_q28(5'(i)));
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + $signed(atan_q28(5'(i)));
				end
				cv_s[i+1] <= cv_s[i];
				cf_s[i+1] <= cf_s[i];
			end
		end
	end

	// Round sine and cosine to Q14.
	assign cos_r = 18'((cx_s[N] + 34'sd32768) >>> 16);
	assign sin_r = 18'((cy_s[N] + 34'sd32768) >>> 16);

	// Stage 1: sine, cosine and the nine coordinate-by-axis products.
	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s1 <= cf_s[N] ? -cos_r : cos_r;
			sin_s1 <= cf_s[N] ? -sin_r : sin_r;
			vtx_s1 <= cv_s[N];
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[k][j] <= $signed(cv_s[N].p[k]) * $signed(cv_s[N].a[j]);
				end
			end
		end
	end

	// Dot and cross product sums.
	always_comb begin
		dsum = 50'(prod_s1[0][0]) + 50'(prod_s1[1][1]) + 50'(prod_s1[2][2]);
		cdiff[0] = 49'(prod_s1[2][1]) - 49'(prod_s1[1][2]);
		cdiff[1] = 49'(prod_s1[0][2]) - 49'(prod_s1[2][0]);
		cdiff[2] = 49'(prod_s1[1][0]) - 49'(prod_s1[0][1]);
	end

	// Stage 2: rounded dot and cross products, one minus cosine.
	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s2 <= 36'((dsum + 50'sd8192) >>> 14);
			for (int k = 0; k < 3; k++) begin
				cr_s2[k] <= 36'((cdiff[k] + 49'sd8192) >>> 14);
			end
			omc_s2 <= 18'sd16384 - cos_s1;
			sin_s2 <= sin_s1;
			cos_s2 <= cos_s1;
			vtx_s2 <= vtx_s1;
		end
	end

	// Stage 3: axis times dot, point times cosine, cross times sine.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				adr_s3[k] <= $signed(vtx_s2.a[k]) * dot_s2;
				pc_s3[k]  <= $signed(vtx_s2.p[k]) * cos_s2;
				crs_s3[k] <= cr_s2[k] * sin_s2;
			end
			omc_s3 <= omc_s2;
			vtx_s3 <= vtx_s2;
		end
	end

	// Stage 4: round the projection onto the axis.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				ad_s4[k]  <= 38'((adr_s3[k] + 52'sd8192) >>> 14);
				pc_s4[k]  <= pc_s3[k];
				crs_s4[k] <= crs_s3[k];
			end
			omc_s4 <= omc_s3;
			vtx_s4 <= vtx_s3;
		end
	end

	// Stage 5: projection times one minus cosine.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				adt_s5[k] <= ad_s4[k] * omc_s4;
				pc_s5[k]  <= pc_s4[k];
				crs_s5[k] <= crs_s4[k];
			end
			vtx_s5 <= vtx_s4;
		end
	end

	// Sum the three terms, round, add the chunk offset and saturate.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tsum[k] = 58'(pc_s5[k]) + 58'(crs_s5[k]) + 58'(adt_s5[k]);
			trnd[k] = 44'((tsum[k] + 58'sd8192) >>> 14);
			wsum[k] = 45'(trnd[k]) + 45'($signed(vtx_s5.pos[k]));
			if (wsum[k] > 45'sd2147483647) begin
				world_d[k] = 32'h7FFF_FFFF;
			end else if (wsum[k] < -45'sd2147483648) begin
				world_d[k] = 32'h8000_0000;
			end else begin
				world_d[k] = wsum[k][31:0];
			end
		end
	end

	// Stage 6: output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			world_s6 <= world_d;
			color_s6 <= vtx_s5.color;
		end
	end

	assign m_axis_tvalid = vld_q[TOP];
	assign m_axis_tdata  = {color_s6, world_s6[2], world_s6[1], world_s6[0]};

endmodule
`default_nettype wire

// ===== design/axis_angle_vertex_transform.sv =====
// Back pipeline: one stage per CORDIC step, with CORDIC_STEPS capped at 24.
// Throughput: one vertex per cycle unless the queue fills; the back pipeline
// stalls as a whole only while the output register holds an untaken transfer.
// Reset: arst_n clears all valid flags and queue pointers asynchronously.
// Top level: front part, queue and back part. Depends on aavt_pkg and its modules.
`default_nettype none
module axis_angle_vertex_transform
	import aavt_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// local_x, local_y, local_z, vertex_color, chunk_pos_x, chunk_pos_y,
	// chunk_pos_z, axis_x, axis_y, axis_z, turn_angle, fade_level, zero pad
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// world_x, world_y, world_z, out_color
	output logic [OUT_W-1:0]      m_axis_tdata
);

	item_t front_item;
	item_t queue_item;
	logic  front_valid;
	logic  queue_full;
	logic  queue_nempty;
	logic  queue_pop;
	logic  queue_push;

	aavt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.item_valid    (front_valid),
		.item_ready    (!queue_full),
		.item          (front_item)
	);

	assign queue_push = front_valid && !queue_full;

	aavt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (queue_push),
		.wr_item (front_item),
		.full    (queue_full),
		.pop     (queue_pop),
		.rd_item (queue_item),
		.nempty  (queue_nempty)
	);

	aavt_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (queue_nempty),
		.item_pop      (queue_pop),
		.item          (queue_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ===== tb/tb_axis_angle_vertex_transform.sv =====
// Testbench for the axis-angle vertex transform: directed vertices, then random ones.
// Depends on aavt_pkg and axis_angle_vertex_transform; compares against a local predictor.
`default_nettype none
module tb_axis_angle_vertex_transform;
	import aavt_pkg::*;

	localparam int STEPS = 16;
	localparam int LATENCY = STEPS + 8;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam longint PI_Q28 = 843314857;
	localparam longint HALF_PI_Q28 = 421657428;
	localparam longint TWO_PI_Q28 = 1686629713;
	localparam longint GAIN_Q30 = 652032874;

	typedef struct packed {
		logic [8:0]  fade;
		logic [15:0] ang;
		logic [15:0] az;
		logic [15:0] ay;
		logic [15:0] ax;
		logic [31:0] cz;
		logic [31:0] cy;
		logic [31:0] cx;
		logic [31:0] color;
		logic [31:0] lz;
		logic [31:0] ly;
		logic [31:0] lx;
	} vertex_t;

	typedef struct packed {
		logic [31:0] color;
		logic [31:0] wz;
		logic [31:0] wy;
		logic [31:0] wx;
	} world_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	world_t expected_world[$];
	int mismatch_count;
	longint cycle_count;
	int send_idle_pct;
	int recv_stall_pct;

	axis_angle_vertex_transform #(.CORDIC_STEPS(STEPS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q14(longint v);
		return (v + 8192) >>> 14;
	endfunction

	function automatic longint arctan_q28(int i);
		longint tbl[24] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
			4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384,
			8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
		return tbl[i];
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Rotate the vertex about its axis, offset by the chunk, and fade the alpha.
	function automatic world_t transform_vertex(vertex_t v);
		world_t w;
		longint z, x, y, dx, dy, s, c, dot, omc, ad, sum;
		longint p[3], a[3], pos[3], cr[3];
		logic [31:0] res[3];
		longint alpha;
		bit flip;
		p[0] = longint'($signed(v.lx));
		p[1] = longint'($signed(v.ly));
		p[2] = longint'($signed(v.lz));
		pos[0] = longint'($signed(v.cx));
		pos[1] = longint'($signed(v.cy));
		pos[2] = longint'($signed(v.cz));
		a[0] = longint'($signed(v.ax));
		a[1] = longint'($signed(v.ay));
		a[2] = longint'($signed(v.az));
		// Reduce the angle into the CORDIC range, noting a half-turn flip.
		z = longint'($signed(v.ang)) * 65536;
		flip = 0;
		if (z > PI_Q28)
			z -= TWO_PI_Q28;
		else if (z < -PI_Q28)
			z += TWO_PI_Q28;
		if (z > HALF_PI_Q28) begin
			z -= PI_Q28;
			flip = 1;
		end else if (z < -HALF_PI_Q28) begin
			z += PI_Q28;
			flip = 1;
		end
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= arctan_q28(i);
			end else begin
				x += dx;
				y -= dy;
				z += arctan_q28(i);
			end
		end
		c = (x + 32768) >>> 16;
		s = (y + 32768) >>> 16;
		if (flip) begin
			c = -c;
			s = -s;
		end
		dot = round_q14(p[0] * a[0] + p[1] * a[1] + p[2] * a[2]);
		cr[0] = round_q14(a[1] * p[2] - a[2] * p[1]);
		cr[1] = round_q14(a[2] * p[0] - a[0] * p[2]);
		cr[2] = round_q14(a[0] * p[1] - a[1] * p[0]);
		omc = 16384 - c;
		for (int k = 0; k < 3; k++) begin
			ad = round_q14(a[k] * dot);
			sum = p[k] * c + cr[k] * s + ad * omc;
			res[k] = clamp32(round_q14(sum) + pos[k]);
		end
		w.wx = res[0];
		w.wy = res[1];
		w.wz = res[2];
		alpha = (longint'(v.color[31:24]) * longint'(v.fade)) >> 8;
		if (alpha > 255)
			alpha = 255;
		w.color = {alpha[7:0], v.color[23:0]};
		return w;
	endfunction

	function automatic vertex_t random_vertex();
		vertex_t v;
		int mode;
		v = '0;
		mode = $urandom_range(0, 9);
		// Mostly moderate coordinates; sometimes full range to hit saturation.
		if (mode < 7) begin
			v.lx = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
			v.ly = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
			v.lz = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
			v.cx = 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
			v.cy = 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
			v.cz = 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
		end else begin
			v.lx = $urandom;
			v.ly = $urandom;
			v.lz = $urandom;
			v.cx = $urandom;
			v.cy = $urandom;
			v.cz = $urandom;
		end
		if (mode < 8) begin
			v.ax = 16'($urandom_range(0, 32768) - 16384);
			v.ay = 16'($urandom_range(0, 32768) - 16384);
			v.az = 16'($urandom_range(0, 32768) - 16384);
			v.ang = 16'($urandom_range(0, 51472) - 25736);
			v.fade = 9'($urandom_range(0, 256));
		end else begin
			v.ax = 16'($urandom);
			v.ay = 16'($urandom);
			v.az = 16'($urandom);
			v.ang = 16'($urandom);
			v.fade = 9'($urandom);
		end
		v.color = $urandom;
		return v;
	endfunction

	// Hand one vertex to the block, idling before it at the current rate.
	task automatic send_vertex(vertex_t v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= IN_W'(v);
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_world = {expected_world, transform_vertex(v)};
		@(negedge clk);
	endtask

	// Receiver: random stall, then compare each output transfer.
	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		world_t got, want;
		cycle_count <= cycle_count + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = world_t'(m_axis_tdata);
			if (expected_world.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected output transfer: %h", got);
			end else begin
				want = expected_world.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected x=%h y=%h z=%h c=%h, got x=%h y=%h z=%h c=%h",
							want.wx, want.wy, want.wz, want.color,
							got.wx, got.wy, got.wz, got.color);
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		vertex_t directed[$];
		vertex_t v;
		int idle_table[4][2];
		int wait_cycles;
		idle_table = '{'{0, 0}, '{88, 0}, '{0, 88}, '{27, 27}};
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: zero, extremes, fade overflow, non-unit axes, angle limits.
		v = '0;
		v.fade = 9'd256;
		directed = {directed, v};
		v.lx = 32'h7FFF_FFFF; v.ly = 32'h8000_0000; v.lz = 32'h7FFF_FFFF;
		v.cx = 32'h7FFF_FFFF; v.cy = 32'h8000_0000; v.cz = 32'h8000_0000;
		v.ax = 16'sd16384; v.ang = 16'sd0; v.color = 32'hFFFF_FFFF; v.fade = 9'h1FF;
		directed = {directed, v};
		v.ax = 16'h8000; v.ay = 16'h7FFF; v.az = 16'hFFFF; v.ang = 16'h7FFF;
		v.fade = 9'd0;
		directed = {directed, v};
		v.ang = 16'h8000; v.fade = 9'd257;
		directed = {directed, v};
		for (int k = 0; k < 12; k++) begin
			v = '0;
			v.lx = 32'sh0001_0000; v.ly = 32'sh0002_0000; v.lz = -32'sh0003_0000;
			v.cx = 32'sh0010_0000;
			v.ax = (k % 3 == 0) ? 16'sd16384 : 16'sd0;
			v.ay = (k % 3 == 1) ? -16'sd16384 : 16'sd0;
			v.az = (k % 3 == 2) ? 16'sd16384 : 16'sd0;
			// Sweep the angle over both signs and the reduction boundaries.
			v.ang = 16'(k * 4681 - 25736);
			v.color = 32'h80A0_B0C0 ^ k;
			v.fade = 9'(k * 23);
			directed = {directed, v};
		end
		foreach (directed[i])
			send_vertex(directed[i]);

		// Random vertices over the idling phases.
		for (int ph = 0; ph < 5; ph++) begin
			send_idle_pct = idle_table[ph % 4][0];
			recv_stall_pct = idle_table[ph % 4][1];
			for (int n = 0; n < 305; n++)
				send_vertex(random_vertex());
		end
		s_axis_tvalid <= 1'b0;
		recv_stall_pct = 0;

		wait_cycles = 0;
		while (expected_world.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && expected_world.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== axis_angle_vertex_transform.f =====
+incdir+design
design/aavt_pkg.sv
design/aavt_front.sv
design/aavt_queue.sv
design/aavt_back.sv
design/axis_angle_vertex_transform.sv
tb/tb_axis_angle_vertex_transform.sv
